@@ sv/ccm_pkg.sv @@
// Shared types and constants of the corridor cell marker.
// No dependencies; used by corridor_cell_marker and ccm_chk.
`default_nettype none

package ccm_pkg;

	localparam int DEF_MAX_WAYPOINTS = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int CELL_W     = 16;
	localparam int COORD_W    = 32;
	localparam int SLOT_W     = 4;
	localparam int COUNT_W    = 5;
	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 32;

	// internal widths, coordinates in units of 2^-17 m
	localparam int K_W   = 48;  // (2*cell+1)*resolution
	localparam int P_W   = 50;  // cell center
	localparam int A_W   = 34;  // waypoint
	localparam int D_W   = 35;  // segment direction, and its magnitude
	localparam int V_W   = 51;  // point minus waypoint, and its magnitude
	localparam int VD_W  = V_W + D_W;
	localparam int VV_W  = 2 * V_W;
	localparam int DD_W  = 2 * D_W;
	localparam int T_W   = VD_W + 2;
	localparam int NV_W  = VV_W + 1;
	localparam int L_W   = DD_W + 1;
	localparam int C_W   = T_W - 1;
	localparam int H_W   = 32;
	localparam int HSQ_W = 2 * H_W;
	localparam int CC_W  = 2 * C_W;
	localparam int HL_W  = HSQ_W + L_W;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLED    = 3'd0,
		CFG_HALF_WIDTH = 3'd1,
		CFG_ORIGIN_X   = 3'd2,
		CFG_ORIGIN_Y   = 3'd3,
		CFG_RESOLUTION = 3'd4,
		CFG_WP_COUNT   = 3'd5
	} cfg_idx_t;

	localparam logic              RST_ENABLED    = 1'b1;
	localparam logic [30:0]       RST_HALF_WIDTH = 31'd49152;
	localparam logic [COORD_W-1:0] RST_ORIGIN    = '0;
	localparam logic [30:0]       RST_RESOLUTION = 31'd3277;
	localparam logic [COUNT_W-1:0] RST_WP_COUNT  = '0;

	typedef struct packed {
		logic              v;
		logic              last;
		logic              live;
		logic [CELL_W-1:0] cx;
		logic [CELL_W-1:0] cy;
		logic              neg_vx;
		logic              neg_vy;
		logic              neg_dx;
		logic              neg_dy;
		logic              near_a;
		logic              near_b;
		logic              far_a;
		logic              far_b;
	} side_t;

endpackage

`default_nettype wire

@@ sv/ccm_mul.sv @@
// Pipelined unsigned multiplier built from 32x32 partial products.
// Three register stages: partial products, row sums, final sum. Uses no package.
`default_nettype none

module ccm_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [AW-1:0]    a,
	input  wire logic [BW-1:0]    b,
	output logic [AW+BW-1:0]      p
);

	localparam int NA = (AW + 31) / 32;
	localparam int NB = (BW + 31) / 32;
	localparam int PW = 32 * (NA + NB);

	logic [NA*32-1:0] a_x;
	logic [NB*32-1:0] b_x;
	logic [63:0]      pp_s1 [NA][NB];
	logic [PW-1:0]    row_n [NA];
	logic [PW-1:0]    row_s2 [NA];
	logic [PW-1:0]    sum_n;
	logic [PW-1:0]    sum_s3;

	assign a_x = (NA*32)'(a);
	assign b_x = (NB*32)'(b);

	for (genvar i = 0; i < NA; i++) begin : g_row
		for (genvar j = 0; j < NB; j++) begin : g_col
			always_ff @(posedge clk) begin
				if (en)
					pp_s1[i][j] <= 64'(a_x[32*i +: 32]) * 64'(b_x[32*j +: 32]);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_n[i] = '0;
			for (int j = 0; j < NB; j++)
				row_n[i] = row_n[i] + (PW'(pp_s1[i][j]) << (32 * j));
		end
	end

	always_comb begin
		sum_n = '0;
		for (int i = 0; i < NA; i++)
			sum_n = sum_n + (row_s2[i] << (32 * i));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s2 <= row_n;
			sum_s3 <= sum_n;
		end
	end

	assign p = sum_s3[AW+BW-1:0];

endmodule

`default_nettype wire

@@ sv/corridor_cell_marker.sv @@
// Corridor cell marker top level: waypoint table, segment issue and distance pipeline.
// Depends on ccm_pkg and ccm_mul.
`default_nettype none

// A load word writes one waypoint slot. A test word is expanded into one pass
// per segment of the waypoint polyline, a single pass when the block is
// disabled or fewer than two waypoints are set. Passes are issued one per cycle,
// unless the output stalls, into a 13-stage segment distance pipeline, and the
// result is registered after the last pass leaves the final stage. The segment
// issue loop, with its two read ports on the waypoint table, sets the rate.
// Output back-pressure stalls the whole pipeline without loss.
module corridor_cell_marker #(
	parameter int MAX_WAYPOINTS = ccm_pkg::DEF_MAX_WAYPOINTS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [ccm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ccm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// wp_index, wp_x, wp_y, cell_x, cell_y, zero pad
	input  wire logic [ccm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// command
	input  wire logic                               s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// out_cell_x, out_cell_y
	output logic [ccm_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
	// outside
	output logic                                    m_axis_tuser
);

	localparam int IW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
	localparam int CW = $clog2(MAX_WAYPOINTS + 1);
	localparam int NS = 13;

	// configuration
	logic                           enabled_q;
	logic [30:0]                    half_width_q;
	logic [ccm_pkg::COORD_W-1:0]    origin_x_q;
	logic [ccm_pkg::COORD_W-1:0]    origin_y_q;
	logic [30:0]                    resolution_q;
	logic [ccm_pkg::COUNT_W-1:0]    wp_count_q;
	logic [ccm_pkg::HSQ_W-1:0]      hsq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q    <= ccm_pkg::RST_ENABLED;
			half_width_q <= ccm_pkg::RST_HALF_WIDTH;
			origin_x_q   <= ccm_pkg::RST_ORIGIN;
			origin_y_q   <= ccm_pkg::RST_ORIGIN;
			resolution_q <= ccm_pkg::RST_RESOLUTION;
			wp_count_q   <= ccm_pkg::RST_WP_COUNT;
		end else if (cfg_we) begin
			case (ccm_pkg::cfg_idx_t'(cfg_index))
				ccm_pkg::CFG_ENABLED:    enabled_q    <= cfg_data[0];
				ccm_pkg::CFG_HALF_WIDTH: half_width_q <= cfg_data[30:0];
				ccm_pkg::CFG_ORIGIN_X:   origin_x_q   <= cfg_data;
				ccm_pkg::CFG_ORIGIN_Y:   origin_y_q   <= cfg_data;
				ccm_pkg::CFG_RESOLUTION: resolution_q <= cfg_data[30:0];
				ccm_pkg::CFG_WP_COUNT:   wp_count_q   <= cfg_data[ccm_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// squared doubled half width, registered from the half width register
	always_ff @(posedge clk) begin
		hsq_q <= 64'({half_width_q, 1'b0}) * 64'({half_width_q, 1'b0});
	end

	// input fields
	logic [ccm_pkg::SLOT_W-1:0]  in_slot;
	logic [63:0]                 in_wp;
	logic [ccm_pkg::CELL_W-1:0]  in_cx;
	logic [ccm_pkg::CELL_W-1:0]  in_cy;

	assign in_slot = s_axis_tdata[3:0];
	assign in_wp   = s_axis_tdata[67:4];
	assign in_cx   = s_axis_tdata[83:68];
	assign in_cy   = s_axis_tdata[99:84];

	// handshake and advance
	logic out_v_q;
	logic adv;
	logic busy_q;
	logic in_acc;

	assign adv           = !out_v_q || m_axis_tready;
	assign s_axis_tready = adv && !busy_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// segment issue
	logic [CW-1:0]              n_eff;
	logic                       segs_ok;
	logic [IW-1:0]              seg_q;
	logic [ccm_pkg::CELL_W-1:0] cx_q;
	logic [ccm_pkg::CELL_W-1:0] cy_q;
	logic                       new_test;
	logic                       busy_last;
	logic [IW-1:0]              rd_a;
	logic [IW-1:0]              rd_b;
	ccm_pkg::side_t             iss;

	assign n_eff = (32'(wp_count_q) > MAX_WAYPOINTS) ? CW'(MAX_WAYPOINTS) : CW'(wp_count_q);
	assign segs_ok   = enabled_q && (n_eff >= CW'(2));
	assign new_test  = s_axis_tvalid && !busy_q && (s_axis_tuser == ccm_pkg::CMD_TEST);
	assign busy_last = (CW'(seg_q) + CW'(2)) == n_eff;
	assign rd_a      = busy_q ? seg_q : '0;
	assign rd_b      = rd_a + IW'(1);

	always_comb begin
		iss      = '0;
		iss.v    = new_test || busy_q;
		if (busy_q) begin
			iss.last = busy_last;
			iss.live = 1'b1;
			iss.cx   = cx_q;
			iss.cy   = cy_q;
		end else begin
			iss.last = !segs_ok || (n_eff == CW'(2));
			iss.live = segs_ok;
			iss.cx   = in_cx;
			iss.cy   = in_cy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			seg_q  <= '0;
		end else if (adv) begin
			if (busy_q) begin
				if (busy_last)
					busy_q <= 1'b0;
				seg_q <= seg_q + IW'(1);
			end else if (in_acc && s_axis_tuser == ccm_pkg::CMD_TEST && segs_ok
					&& n_eff > CW'(2)) begin
				busy_q <= 1'b1;
				seg_q  <= IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cx_q <= in_cx;
			cy_q <= in_cy;
		end
	end

	// waypoint table: x low, y high
	logic [63:0] wp_mem [MAX_WAYPOINTS];
	logic [63:0] wa_s1;
	logic [63:0] wb_s1;

	always_ff @(posedge clk) begin
		if (in_acc && s_axis_tuser == ccm_pkg::CMD_LOAD && 32'(in_slot) < MAX_WAYPOINTS)
			wp_mem[IW'(in_slot)] <= in_wp;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wa_s1 <= wp_mem[rd_a];
			wb_s1 <= wp_mem[rd_b];
		end
	end

	// sideband shift line
	ccm_pkg::side_t side_s [1:NS];
	ccm_pkg::side_t side_n [2:NS];

	// stage 2
	logic [ccm_pkg::A_W-1:0] ax_s2, ay_s2, bx_s2, by_s2;
	logic [ccm_pkg::D_W-1:0] dx_s2, dy_s2;
	logic [ccm_pkg::K_W-1:0] kx_s2, ky_s2;
	// stage 3
	logic [ccm_pkg::A_W-1:0] ax_s3, ay_s3, bx_s3, by_s3;
	logic [ccm_pkg::D_W-1:0] dx_s3, dy_s3;
	logic [ccm_pkg::P_W-1:0] px_s3, py_s3;
	// stage 4
	logic [ccm_pkg::V_W-1:0] vx_s4, vy_s4, wx_s4, wy_s4;
	logic [ccm_pkg::D_W-1:0] dx_s4, dy_s4;
	// stage 5
	logic [ccm_pkg::V_W-1:0] mvx_s5, mvy_s5, mwx_s5, mwy_s5;
	logic [ccm_pkg::D_W-1:0] mdx_s5, mdy_s5;
	// stage 8
	logic [ccm_pkg::VD_W-1:0] vxdx_s8, vydy_s8, vxdy_s8, vydx_s8;
	logic [ccm_pkg::VV_W-1:0] vxx_s8, vyy_s8, wxx_s8, wyy_s8;
	logic [ccm_pkg::DD_W-1:0] dxx_s8, dyy_s8;
	// stage 9
	logic [ccm_pkg::T_W-1:0]  t_s9, c_s9;
	logic [ccm_pkg::NV_W-1:0] nv_s9, nw_s9;
	logic [ccm_pkg::L_W-1:0]  lsq_s9;
	// stage 10
	logic [ccm_pkg::C_W-1:0]  cabs_s10;
	logic [ccm_pkg::L_W-1:0]  lsq_s10;
	// stage 13
	logic [ccm_pkg::CC_W-1:0] cc_s13;
	logic [ccm_pkg::HL_W-1:0] hl_s13;

	function automatic logic [ccm_pkg::T_W-1:0] sgn_ext(
		input logic [ccm_pkg::VD_W-1:0] m, input logic neg);
		logic [ccm_pkg::T_W-1:0] r;
		r = ccm_pkg::T_W'(m);
		return neg ? -r : r;
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s2 <= {wa_s1[31], wa_s1[31:0], 1'b0};
			ay_s2 <= {wa_s1[63], wa_s1[63:32], 1'b0};
			bx_s2 <= {wb_s1[31], wb_s1[31:0], 1'b0};
			by_s2 <= {wb_s1[63], wb_s1[63:32], 1'b0};
			dx_s2 <= {wb_s1[31], wb_s1[31], wb_s1[31:0], 1'b0}
				- {wa_s1[31], wa_s1[31], wa_s1[31:0], 1'b0};
			dy_s2 <= {wb_s1[63], wb_s1[63], wb_s1[63:32], 1'b0}
				- {wa_s1[63], wa_s1[63], wa_s1[63:32], 1'b0};
			kx_s2 <= ccm_pkg::K_W'({side_s[1].cx, 1'b1}) * ccm_pkg::K_W'(resolution_q);
			ky_s2 <= ccm_pkg::K_W'({side_s[1].cy, 1'b1}) * ccm_pkg::K_W'(resolution_q);

			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
			bx_s3 <= bx_s2;
			by_s3 <= by_s2;
			dx_s3 <= dx_s2;
			dy_s3 <= dy_s2;
			px_s3 <= {{17{origin_x_q[31]}}, origin_x_q, 1'b0} + {2'b00, kx_s2};
			py_s3 <= {{17{origin_y_q[31]}}, origin_y_q, 1'b0} + {2'b00, ky_s2};

			vx_s4 <= {px_s3[49], px_s3} - {{17{ax_s3[33]}}, ax_s3};
			vy_s4 <= {py_s3[49], py_s3} - {{17{ay_s3[33]}}, ay_s3};
			wx_s4 <= {px_s3[49], px_s3} - {{17{bx_s3[33]}}, bx_s3};
			wy_s4 <= {py_s3[49], py_s3} - {{17{by_s3[33]}}, by_s3};
			dx_s4 <= dx_s3;
			dy_s4 <= dy_s3;

			mvx_s5 <= vx_s4[50] ? -vx_s4 : vx_s4;
			mvy_s5 <= vy_s4[50] ? -vy_s4 : vy_s4;
			mwx_s5 <= wx_s4[50] ? -wx_s4 : wx_s4;
			mwy_s5 <= wy_s4[50] ? -wy_s4 : wy_s4;
			mdx_s5 <= dx_s4[34] ? -dx_s4 : dx_s4;
			mdy_s5 <= dy_s4[34] ? -dy_s4 : dy_s4;

			t_s9 <= sgn_ext(vxdx_s8, side_s[8].neg_vx ^ side_s[8].neg_dx)
				+ sgn_ext(vydy_s8, side_s[8].neg_vy ^ side_s[8].neg_dy);
			c_s9 <= sgn_ext(vxdy_s8, side_s[8].neg_vx ^ side_s[8].neg_dy)
				- sgn_ext(vydx_s8, side_s[8].neg_vy ^ side_s[8].neg_dx);
			nv_s9  <= ccm_pkg::NV_W'(vxx_s8) + ccm_pkg::NV_W'(vyy_s8);
			nw_s9  <= ccm_pkg::NV_W'(wxx_s8) + ccm_pkg::NV_W'(wyy_s8);
			lsq_s9 <= ccm_pkg::L_W'(dxx_s8) + ccm_pkg::L_W'(dyy_s8);

			cabs_s10 <= c_s9[ccm_pkg::T_W-1] ? ccm_pkg::C_W'(-c_s9) : ccm_pkg::C_W'(c_s9);
			lsq_s10  <= lsq_s9;
		end
	end

	ccm_mul #(.AW(ccm_pkg::V_W), .BW(ccm_pkg::D_W)) u_vxdx (
		.clk(clk), .en(adv), .a(mvx_s5), .b(mdx_s5), .p(vxdx_s8));
	ccm_mul #(.AW(ccm_pkg::V_W), .BW(ccm_pkg::D_W)) u_vydy (
		.clk(clk), .en(adv), .a(mvy_s5), .b(mdy_s5), .p(vydy_s8));
	ccm_mul #(.AW(ccm_pkg::V_W), .BW(ccm_pkg::D_W)) u_vxdy (
		.clk(clk), .en(adv), .a(mvx_s5), .b(mdy_s5), .p(vxdy_s8));
	ccm_mul #(.AW(ccm_pkg::V_W), .BW(ccm_pkg::D_W)) u_vydx (
		.clk(clk), .en(adv), .a(mvy_s5), .b(mdx_s5), .p(vydx_s8));
	ccm_mul #(.AW(ccm_pkg::V_W), .BW(ccm_pkg::V_W)) u_vxx (
		.clk(clk), .en(adv), .a(mvx_s5), .b(mvx_s5), .p(vxx_s8));
	ccm_mul #(.AW(ccm_pkg::V_W), .BW(ccm_pkg::V_W)) u_vyy (
		.clk(clk), .en(adv), .a(mvy_s5), .b(mvy_s5), .p(vyy_s8));
	ccm_mul #(.AW(ccm_pkg::V_W), .BW(ccm_pkg::V_W)) u_wxx (
		.clk(clk), .en(adv), .a(mwx_s5), .b(mwx_s5), .p(wxx_s8));
	ccm_mul #(.AW(ccm_pkg::V_W), .BW(ccm_pkg::V_W)) u_wyy (
		.clk(clk), .en(adv), .a(mwy_s5), .b(mwy_s5), .p(wyy_s8));
	ccm_mul #(.AW(ccm_pkg::D_W), .BW(ccm_pkg::D_W)) u_dxx (
		.clk(clk), .en(adv), .a(mdx_s5), .b(mdx_s5), .p(dxx_s8));
	ccm_mul #(.AW(ccm_pkg::D_W), .BW(ccm_pkg::D_W)) u_dyy (
		.clk(clk), .en(adv), .a(mdy_s5), .b(mdy_s5), .p(dyy_s8));
	ccm_mul #(.AW(ccm_pkg::C_W), .BW(ccm_pkg::C_W)) u_cc (
		.clk(clk), .en(adv), .a(cabs_s10), .b(cabs_s10), .p(cc_s13));
	ccm_mul #(.AW(ccm_pkg::HSQ_W), .BW(ccm_pkg::L_W)) u_hl (
		.clk(clk), .en(adv), .a(hsq_q), .b(lsq_s10), .p(hl_s13));

	always_comb begin
		for (int k = 2; k <= NS; k++)
			side_n[k] = side_s[k-1];
		// zero-length segment drops out
		side_n[3].live = side_s[2].live && !(dx_s2 == '0 && dy_s2 == '0);
		side_n[5].neg_vx = vx_s4[50];
		side_n[5].neg_vy = vy_s4[50];
		side_n[5].neg_dx = dx_s4[34];
		side_n[5].neg_dy = dy_s4[34];
		side_n[10].near_a = t_s9[ccm_pkg::T_W-1] || (t_s9 == '0);
		side_n[10].near_b = $signed(t_s9) >= $signed(ccm_pkg::T_W'(lsq_s9));
		side_n[10].far_a  = nv_s9 > ccm_pkg::NV_W'(hsq_q);
		side_n[10].far_b  = nw_s9 > ccm_pkg::NV_W'(hsq_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NS; k++)
				side_s[k] <= '0;
		end else if (adv) begin
			side_s[1] <= iss;
			for (int k = 2; k <= NS; k++)
				side_s[k] <= side_n[k];
		end
	end

	// per-test accumulation and output register
	logic acc_any_q;
	logic acc_far_q;
	logic seg_far;
	logic any_n;
	logic far_n;
	logic out_outside_q;
	logic [ccm_pkg::CELL_W-1:0] out_cx_q;
	logic [ccm_pkg::CELL_W-1:0] out_cy_q;

	assign seg_far = side_s[NS].near_a ? side_s[NS].far_a :
		side_s[NS].near_b ? side_s[NS].far_b : (cc_s13 > ccm_pkg::CC_W'(hl_s13));
	assign any_n = acc_any_q || side_s[NS].live;
	assign far_n = acc_far_q && (!side_s[NS].live || seg_far);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_any_q <= 1'b0;
			acc_far_q <= 1'b1;
			out_v_q   <= 1'b0;
		end else if (adv) begin
			out_v_q <= side_s[NS].v && side_s[NS].last;
			if (side_s[NS].v) begin
				if (side_s[NS].last) begin
					acc_any_q <= 1'b0;
					acc_far_q <= 1'b1;
				end else begin
					acc_any_q <= any_n;
					acc_far_q <= far_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && side_s[NS].v && side_s[NS].last) begin
			out_outside_q <= any_n && far_n;
			out_cx_q      <= side_s[NS].cx;
			out_cy_q      <= side_s[NS].cy;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = out_outside_q;
	assign m_axis_tdata  = {out_cy_q, out_cx_q};

endmodule

`default_nettype wire

@@ sv/ccm_chk.sv @@
// Port-level checks of the corridor cell marker, bound to the top level.
// Depends on ccm_pkg and corridor_cell_marker.
`default_nettype none

module ccm_chk (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_axis_tvalid,
	input wire logic                            s_axis_tready,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [ccm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input wire logic                            m_axis_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
			&& $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word dropped or changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output stalled");

	a_quiet_reset: assert property (@(posedge clk)
		$past(!arst_n) |-> !m_axis_tvalid)
		else $error("result word right after reset");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |=> !m_axis_tvalid)
		else $error("result word before any test word could finish");

endmodule

bind corridor_cell_marker ccm_chk u_ccm_chk (.*);

`default_nettype wire
